// ===== rtl/masked_multi_pattern_matcher_defines.svh =====
// Assertion macros for the masked multi-pattern matcher.
// Included by the top level; depends on nothing.
`ifndef MASKED_MULTI_PATTERN_MATCHER_DEFINES_SVH
`define MASKED_MULTI_PATTERN_MATCHER_DEFINES_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define MMPM_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on the rising clock, off during reset
`define MMPM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mmpm_pkg.sv =====
// Shared types and constants of the masked multi-pattern matcher.
// Used by every module of the block; depends on nothing.
package mmpm_pkg;

    localparam int NUM_PATTERNS      = 8;
    localparam int MAX_PATTERN_WORDS = 8;
    localparam int WORD_W            = 32;
    localparam int PAT_W             = 3;
    localparam int WSEL_W            = 3;
    localparam int LEN_W             = 4;
    localparam int HIST_DEPTH        = MAX_PATTERN_WORDS - 1;
    localparam int FILL_W            = 3;
    localparam int TAB_DEPTH         = NUM_PATTERNS * MAX_PATTERN_WORDS;

    typedef enum logic [1:0] {
        OP_LOAD_WORD = 2'd0,
        OP_SET_LEN   = 2'd1,
        OP_DATA      = 2'd2,
        OP_NONE      = 2'd3
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [PAT_W-1:0]   pattern_sel;
        logic [WSEL_W-1:0]  word_sel;
        logic [WORD_W-1:0]  match_value;
        logic [WORD_W-1:0]  mask_value;
        logic [LEN_W-1:0]   pattern_length;
        logic [WORD_W-1:0]  data_word;
        logic               first_word;
    } in_word_t;

    typedef struct packed {
        logic [PAT_W-1:0]   hit_pattern;
        logic [WORD_W-1:0]  hit_offset;
        logic               last_hit;
    } out_word_t;

    // words[0] is the current data word, words[k] the word k items back
    typedef struct packed {
        logic [MAX_PATTERN_WORDS-1:0][WORD_W-1:0] words;
        logic [FILL_W-1:0]                        fill;
        logic [WORD_W-1:0]                        base;
    } win_view_t;

    typedef struct packed {
        logic [NUM_PATTERNS-1:0]            hit_vec;
        logic [WORD_W-1:0]                  base;
        logic [NUM_PATTERNS-1:0][LEN_W-1:0] lens;
    } hit_info_t;

endpackage

// ===== rtl/mmpm_window.sv =====
// Buffer history of the matcher: previous data words, fill count and word index.
// Depends on mmpm_pkg.
module mmpm_window (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              shift_en,
    input  logic                              first,
    input  logic [mmpm_pkg::WORD_W-1:0]       data,
    output mmpm_pkg::win_view_t               view
);

    logic [mmpm_pkg::HIST_DEPTH-1:0][mmpm_pkg::WORD_W-1:0] hist_reg, hist_next, hist_eff;
    logic [mmpm_pkg::FILL_W-1:0] fill_reg, fill_next, fill_eff;
    logic [mmpm_pkg::WORD_W-1:0] seen_reg, seen_next, seen_eff;

    always_comb begin
        if (first) begin
            hist_eff = '0;
            fill_eff = '0;
            seen_eff = '0;
        end else begin
            hist_eff = hist_reg;
            fill_eff = fill_reg;
            seen_eff = seen_reg;
        end
        view.words[0] = data;
        for (int k = 1; k < mmpm_pkg::MAX_PATTERN_WORDS; k++) begin
            view.words[k] = hist_eff[k-1];
        end
        view.fill = fill_eff;
        view.base = seen_eff;
    end

    always_comb begin
        hist_next[0] = data;
        for (int k = 1; k < mmpm_pkg::HIST_DEPTH; k++) begin
            hist_next[k] = hist_eff[k-1];
        end
        if (fill_eff < mmpm_pkg::FILL_W'(mmpm_pkg::HIST_DEPTH)) begin
            fill_next = fill_eff + mmpm_pkg::FILL_W'(1);
        end else begin
            fill_next = fill_eff;
        end
        seen_next = seen_eff + mmpm_pkg::WORD_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg <= '0;
            fill_reg <= '0;
            seen_reg <= '0;
        end else if (shift_en) begin
            hist_reg <= hist_next;
            fill_reg <= fill_next;
            seen_reg <= seen_next;
        end
    end

endmodule

// ===== rtl/mmpm_table.sv =====
// Pattern table (match, mask, length) and the parallel window compare.
// Depends on mmpm_pkg.
module mmpm_table (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  mmpm_pkg::in_word_t    item,
    input  mmpm_pkg::win_view_t   view,
    output mmpm_pkg::hit_info_t   info
);

    logic [mmpm_pkg::WORD_W-1:0] match_mem [mmpm_pkg::TAB_DEPTH];
    logic [mmpm_pkg::WORD_W-1:0] mask_mem  [mmpm_pkg::TAB_DEPTH];
    logic [mmpm_pkg::NUM_PATTERNS-1:0][mmpm_pkg::LEN_W-1:0] len_reg;
    logic [mmpm_pkg::LEN_W-1:0] len_sat;

    assign len_sat = (item.pattern_length > mmpm_pkg::LEN_W'(mmpm_pkg::MAX_PATTERN_WORDS))
                   ? mmpm_pkg::LEN_W'(mmpm_pkg::MAX_PATTERN_WORDS) : item.pattern_length;

    always_ff @(posedge aclk) begin
        if (wr_en && item.op == mmpm_pkg::OP_LOAD_WORD) begin
            match_mem[{item.pattern_sel, item.word_sel}] <= item.match_value;
            mask_mem[{item.pattern_sel, item.word_sel}]  <= item.mask_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
        end else if (wr_en && item.op == mmpm_pkg::OP_SET_LEN) begin
            len_reg[item.pattern_sel] <= len_sat;
        end
    end

    always_comb begin
        logic [mmpm_pkg::LEN_W-1:0]  back;
        logic [mmpm_pkg::LEN_W-1:0]  avail;
        logic [mmpm_pkg::PAT_W+mmpm_pkg::WSEL_W-1:0] addr;
        logic                        all_ok;
        avail = {1'b0, view.fill} + mmpm_pkg::LEN_W'(1);
        for (int p = 0; p < mmpm_pkg::NUM_PATTERNS; p++) begin
            all_ok = 1'b1;
            for (int x = 0; x < mmpm_pkg::MAX_PATTERN_WORDS; x++) begin
                back = len_reg[p] - mmpm_pkg::LEN_W'(1) - mmpm_pkg::LEN_W'(x);
                addr = {mmpm_pkg::PAT_W'(p), mmpm_pkg::WSEL_W'(x)};
                if (mmpm_pkg::LEN_W'(x) < len_reg[p]) begin
                    if ((view.words[back[mmpm_pkg::WSEL_W-1:0]] & mask_mem[addr])
                        != match_mem[addr]) begin
                        all_ok = 1'b0;
                    end
                end
            end
            info.hit_vec[p] = (item.op == mmpm_pkg::OP_DATA) && (len_reg[p] != '0)
                            && (len_reg[p] <= avail) && all_ok;
        end
        info.base = view.base;
        info.lens = len_reg;
    end

endmodule

// ===== rtl/mmpm_result.sv =====
// Result stage: holds the hits of one word and hands them out lowest pattern first.
// Depends on mmpm_pkg.
module mmpm_result (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  mmpm_pkg::hit_info_t   info_in,
    output logic                  free,
    output logic                  m_valid,
    input  logic                  m_ready,
    output mmpm_pkg::out_word_t   m_payload
);

    logic [mmpm_pkg::NUM_PATTERNS-1:0] pend_reg, pend_next, sel_oh;
    logic [mmpm_pkg::WORD_W-1:0] base_reg;
    logic [mmpm_pkg::NUM_PATTERNS-1:0][mmpm_pkg::LEN_W-1:0] lens_reg;
    logic [mmpm_pkg::PAT_W-1:0] sel_idx;
    logic last;

    always_comb begin
        sel_idx = '0;
        for (int i = mmpm_pkg::NUM_PATTERNS - 1; i >= 0; i--) begin
            if (pend_reg[i]) begin
                sel_idx = mmpm_pkg::PAT_W'(i);
            end
        end
        sel_oh = mmpm_pkg::NUM_PATTERNS'(1) << sel_idx;
        last   = (pend_reg & ~sel_oh) == '0;
    end

    assign m_valid = pend_reg != '0;
    assign free    = !m_valid || (m_ready && last);

    assign m_payload.hit_pattern = sel_idx;
    assign m_payload.hit_offset  = base_reg - mmpm_pkg::WORD_W'(lens_reg[sel_idx])
                                 + mmpm_pkg::WORD_W'(1);
    assign m_payload.last_hit    = last;

    always_comb begin
        pend_next = pend_reg;
        if (load) begin
            pend_next = info_in.hit_vec;
        end else if (m_valid && m_ready) begin
            pend_next = pend_reg & ~sel_oh;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            base_reg <= info_in.base;
            lens_reg <= info_in.lens;
        end
    end

endmodule

// ===== rtl/masked_multi_pattern_matcher.sv =====
// Top level of the masked multi-pattern matcher: input register, history,
// pattern table and result stage. Depends on mmpm_pkg and the defines header.
//
//   port group   dir   payload type           role
//   s_*          in    mmpm_pkg::in_word_t    pattern loads and buffer data words
//   m_*          out   mmpm_pkg::out_word_t   one word per pattern hit
//
// A word is registered on accept and compared against all patterns in the next cycle;
// its hits are registered in the result stage when the word advances out of the input register.
// One input word per cycle unless stalled; a data word with k hits holds the result stage
// until its last hit leaves, and the next word with hits waits in the input register till then.
// Loads and words without hits pass while hits are still draining.
// Reset is synchronous: history, fill count, lengths and pending hits clear.
`include "masked_multi_pattern_matcher_defines.svh"

module masked_multi_pattern_matcher (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  mmpm_pkg::in_word_t    s_payload,
    output logic                  m_valid,
    input  logic                  m_ready,
    output mmpm_pkg::out_word_t   m_payload
);

    mmpm_pkg::in_word_t   in_reg;
    logic                 in_valid_reg, in_valid_next;
    mmpm_pkg::win_view_t  view;
    mmpm_pkg::hit_info_t  info;
    logic                 hit_any, res_free, advance, res_load, shift_en;

    assign hit_any  = info.hit_vec != '0;
    assign advance  = in_valid_reg && (!hit_any || res_free);
    assign res_load = advance && hit_any;
    assign shift_en = advance && (in_reg.op == mmpm_pkg::OP_DATA);
    assign s_ready  = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_payload;
        end
    end

    mmpm_window u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (shift_en),
        .first    (in_reg.first_word),
        .data     (in_reg.data_word),
        .view     (view)
    );

    mmpm_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (advance),
        .item    (in_reg),
        .view    (view),
        .info    (info)
    );

    mmpm_result u_result (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (res_load),
        .info_in   (info),
        .free      (res_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    `MMPM_ASSERT_NOW(a_load_when_free, aclk, aresetn, res_load, res_free,
        "hits loaded while result stage busy")
    `MMPM_ASSERT_NEXT(a_drain_ends, aclk, aresetn,
        m_valid && m_ready && m_payload.last_hit && !res_load, !m_valid,
        "result stage still valid after last hit")
    `MMPM_ASSERT_NEXT(a_in_hold, aclk, aresetn, in_valid_reg && !advance,
        in_valid_reg && $stable(in_reg), "stalled input word lost or changed")

endmodule
